FILE: hw/rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Types, constants and datapath command codes of the refresh tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

  // Sizing. PARTITIONS, LIST_DEPTH and ROW_GROUPS are powers of two.
  localparam int PARTITIONS = 8;
  localparam int LIST_DEPTH = 64;
  localparam int ROW_GROUPS = 1024;
  localparam int HOLD_DEPTH = 8;

  localparam int PART_W  = $clog2(PARTITIONS);
  localparam int IDX_W   = $clog2(LIST_DEPTH);
  localparam int LEN_W   = IDX_W + 1;
  localparam int RG_W    = $clog2(ROW_GROUPS);
  localparam int ADDR_W  = PART_W + IDX_W;
  localparam int ENTRIES = PARTITIONS * LIST_DEPTH;
  localparam int HOLD_IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int HCNT_W  = $clog2(HOLD_DEPTH + 1);

  localparam logic [47:0] SUM_MAX = '1;
  localparam logic [31:0] U32_MAX = '1;

  // Result status codes.
  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_DEFERRED = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_TICK     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_SUB_WINDOW = 2'd0;
  localparam logic [1:0] REG_REFR_COST  = 2'd1;
  localparam logic [1:0] REG_RET_LIMIT  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] offset_in_window;
    logic [9:0]  row_grp;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  hit_partition;
    logic [5:0]  hit_index;
    logic        retention_ok;
    logic [47:0] refresh_latency_total;
    logic [47:0] valid_bus_total;
    logic [31:0] window_count;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_DEFER,
    OP_DROP,
    OP_SWEEP_START,
    OP_NEXT_PART,
    OP_TO_CP,
    OP_READ,
    OP_HIT,
    OP_NEXT_ENTRY,
    OP_APPEND,
    OP_TICK_SUMS,
    OP_AGE_WR,
    OP_SET_TAIL,
    OP_REPLAY_LOAD,
    OP_KEEP,
    OP_REPLAY_END,
    OP_RET_START,
    OP_RET_CMP,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic is_tick;
    logic replay;
    logic in_win;
    logic hold_full;
    logic scan_end;
    logic last_part;
    logic match;
    logic replay_end;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: hw/rtl/prt_ram.sv
// ----------------------------------------------------------------------------
// prt_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/prt_ctrl.sv
// ----------------------------------------------------------------------------
// prt_ctrl
// Sequencer: walks the lists for lookup, aging and retention sweeps and
// replays held requests after a tick.
// ----------------------------------------------------------------------------
module prt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  prt_pkg::dp_status_t  status_i,
  output prt_pkg::dp_op_e      op_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RCHECK, S_SRCH, S_SCMP, S_APPEND, S_AGE_RD,
    S_AGE_WR, S_SET_TAIL, S_REPLAY, S_RET, S_RET_RD, S_RET_CMP, S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = prt_pkg::OP_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = prt_pkg::OP_LATCH;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.is_tick) begin
          op_o    = prt_pkg::OP_TICK_SUMS;
          state_d = S_AGE_RD;
        end else if (status_i.in_win) begin
          op_o    = prt_pkg::OP_SWEEP_START;
          state_d = S_SRCH;
        end else if (!status_i.hold_full) begin
          op_o    = prt_pkg::OP_DEFER;
          state_d = S_RET;
        end else begin
          op_o    = prt_pkg::OP_DROP;
          state_d = S_RET;
        end
      end
      S_RCHECK: begin
        if (status_i.in_win) begin
          op_o    = prt_pkg::OP_SWEEP_START;
          state_d = S_SRCH;
        end else begin
          op_o    = prt_pkg::OP_KEEP;
          state_d = S_REPLAY;
        end
      end
      S_SRCH: begin
        if (!status_i.scan_end) begin
          op_o    = prt_pkg::OP_READ;
          state_d = S_SCMP;
        end else if (status_i.last_part) begin
          op_o    = prt_pkg::OP_TO_CP;
          state_d = S_APPEND;
        end else begin
          op_o = prt_pkg::OP_NEXT_PART;
        end
      end
      S_SCMP: begin
        if (status_i.match) begin
          op_o    = prt_pkg::OP_HIT;
          state_d = status_i.replay ? S_REPLAY : S_RET;
        end else begin
          op_o    = prt_pkg::OP_NEXT_ENTRY;
          state_d = S_SRCH;
        end
      end
      S_APPEND: begin
        op_o    = prt_pkg::OP_APPEND;
        state_d = status_i.replay ? S_REPLAY : S_RET;
      end
      S_AGE_RD: begin
        if (!status_i.scan_end) begin
          op_o    = prt_pkg::OP_READ;
          state_d = S_AGE_WR;
        end else if (status_i.last_part) begin
          op_o    = prt_pkg::OP_TO_CP;
          state_d = S_SET_TAIL;
        end else begin
          op_o = prt_pkg::OP_NEXT_PART;
        end
      end
      S_AGE_WR: begin
        op_o    = prt_pkg::OP_AGE_WR;
        state_d = S_AGE_RD;
      end
      S_SET_TAIL: begin
        op_o    = prt_pkg::OP_SET_TAIL;
        state_d = S_REPLAY;
      end
      S_REPLAY: begin
        if (status_i.replay_end) begin
          op_o    = prt_pkg::OP_REPLAY_END;
          state_d = S_RET;
        end else begin
          op_o    = prt_pkg::OP_REPLAY_LOAD;
          state_d = S_RCHECK;
        end
      end
      S_RET: begin
        op_o    = prt_pkg::OP_RET_START;
        state_d = S_RET_RD;
      end
      S_RET_RD: begin
        if (!status_i.scan_end) begin
          op_o    = prt_pkg::OP_READ;
          state_d = S_RET_CMP;
        end else if (status_i.last_part) begin
          state_d = S_DONE;
        end else begin
          op_o = prt_pkg::OP_NEXT_PART;
        end
      end
      S_RET_CMP: begin
        op_o    = prt_pkg::OP_RET_CMP;
        state_d = S_RET_RD;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          op_o    = prt_pkg::OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/prt_dp.sv
// ----------------------------------------------------------------------------
// prt_dp
// Datapath: configuration, list storage, totals, hold queue and result
// register. Each cycle it carries out the command of the sequencer.
// ----------------------------------------------------------------------------
module prt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  prt_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output prt_pkg::out_item_t   out_data_o,
  input  prt_pkg::dp_op_e      op_i,
  output prt_pkg::dp_status_t  status_o
);

  localparam int PW = prt_pkg::PART_W;
  localparam int LW = prt_pkg::LEN_W;
  localparam int RW = prt_pkg::RG_W;
  localparam int HW = prt_pkg::HOLD_IW;
  localparam int CW = prt_pkg::HCNT_W;

  logic [31:0] sub_win_q, ret_lim_q;
  logic [15:0] cost_q;

  logic [PW-1:0] cp_q, p_q;
  logic [LW-1:0] i_q;
  logic [31:0]   round_q;
  logic [LW-1:0] len_q  [prt_pkg::PARTITIONS];
  logic [31:0]   tail_q [prt_pkg::PARTITIONS];
  logic [47:0]   lat_q, bus_q;
  logic [RW-1:0] held_q [prt_pkg::HOLD_DEPTH];
  logic [CW-1:0] hcnt_q, k_q, keep_q;

  logic          tick_q, replay_q;
  logic [31:0]   off_q;
  logic [RW-1:0] rg_q;
  logic [2:0]    res_st_q;
  logic [2:0]    res_part_q;
  logic [5:0]    res_idx_q;
  logic          ok_q;
  logic          out_valid_q;
  prt_pkg::out_item_t out_q;

  // List RAM ports.
  logic [prt_pkg::ADDR_W-1:0] raddr, waddr;
  logic                       rg_we, age_we;
  logic [31:0]                age_wdata, age_rdata;
  logic [RW-1:0]              rg_rdata;

  logic [31:0]   tail_cur, decay, aged;
  logic [32:0]   aged_sum;
  logic [48:0]   lat_sum, bus_sum_n;
  logic [31:0]   bus_gain;
  logic          list_full;
  logic [LW-1:0] len_cur;

  assign tail_cur  = tail_q[cp_q];
  assign len_cur   = len_q[p_q];
  assign list_full = (len_cur >= LW'(prt_pkg::LIST_DEPTH));
  assign decay     = ret_lim_q >> PW;
  assign aged_sum  = {1'b0, age_rdata} + {1'b0, decay};
  assign aged      = aged_sum[32] ? prt_pkg::U32_MAX : aged_sum[31:0];
  assign lat_sum   = {1'b0, lat_q} + {17'd0, tail_cur};
  assign bus_gain  = (tail_cur < sub_win_q) ? (sub_win_q - tail_cur - 32'd1) : 32'd0;
  assign bus_sum_n = {1'b0, bus_q} + {17'd0, bus_gain};

  assign raddr = {p_q, i_q[prt_pkg::IDX_W-1:0]};

  always_comb begin
    rg_we     = 1'b0;
    age_we    = 1'b0;
    waddr     = raddr;
    age_wdata = 32'd0;
    case (op_i)
      prt_pkg::OP_HIT: age_we = 1'b1;
      prt_pkg::OP_APPEND: begin
        waddr  = {p_q, len_cur[prt_pkg::IDX_W-1:0]};
        rg_we  = !list_full;
        age_we = !list_full;
      end
      prt_pkg::OP_AGE_WR: begin
        age_we    = 1'b1;
        age_wdata = (p_q == cp_q) ? 32'd0 : aged;
      end
      default: ;
    endcase
  end

  prt_ram #(.WIDTH(RW), .DEPTH(prt_pkg::ENTRIES)) u_rg_ram (
    .clk_i   (clk_i),
    .we_i    (rg_we),
    .waddr_i (waddr),
    .wdata_i (rg_q),
    .raddr_i (raddr),
    .rdata_o (rg_rdata)
  );

  prt_ram #(.WIDTH(32), .DEPTH(prt_pkg::ENTRIES)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (waddr),
    .wdata_i (age_wdata),
    .raddr_i (raddr),
    .rdata_o (age_rdata)
  );

  always_comb begin
    status_o.is_tick    = tick_q;
    status_o.replay     = replay_q;
    status_o.in_win     = (tail_cur < sub_win_q) && (off_q < (sub_win_q - tail_cur));
    status_o.hold_full  = (hcnt_q >= CW'(prt_pkg::HOLD_DEPTH));
    status_o.scan_end   = (i_q >= len_cur);
    status_o.last_part  = (p_q == PW'(prt_pkg::PARTITIONS - 1));
    status_o.match      = (rg_rdata == rg_q);
    status_o.replay_end = (k_q >= hcnt_q);
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    case (op_i)
      prt_pkg::OP_LATCH: begin
        off_q <= in_data_i.offset_in_window;
        rg_q  <= RW'(in_data_i.row_grp);
      end
      prt_pkg::OP_DEFER: held_q[hcnt_q[HW-1:0]] <= rg_q;
      prt_pkg::OP_KEEP:  held_q[keep_q[HW-1:0]] <= held_q[k_q[HW-1:0]];
      prt_pkg::OP_REPLAY_LOAD: begin
        rg_q  <= held_q[k_q[HW-1:0]];
        off_q <= 32'(k_q);
      end
      prt_pkg::OP_OUT: begin
        out_q.status                <= res_st_q;
        out_q.hit_partition         <= 3'(res_part_q);
        out_q.hit_index             <= res_idx_q;
        out_q.retention_ok          <= ok_q;
        out_q.refresh_latency_total <= lat_q;
        out_q.valid_bus_total       <= bus_q;
        out_q.window_count          <= round_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_win_q   <= 32'd8000000;
      cost_q      <= 16'd350;
      ret_lim_q   <= 32'd64000000;
      cp_q        <= '0;
      p_q         <= '0;
      i_q         <= '0;
      round_q     <= '0;
      lat_q       <= '0;
      bus_q       <= '0;
      hcnt_q      <= '0;
      k_q         <= '0;
      keep_q      <= '0;
      tick_q      <= 1'b0;
      replay_q    <= 1'b0;
      res_st_q    <= prt_pkg::ST_NEW;
      res_part_q  <= '0;
      res_idx_q   <= '0;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
      for (int n = 0; n < prt_pkg::PARTITIONS; n++) begin
        len_q[n]  <= '0;
        tail_q[n] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          prt_pkg::REG_SUB_WINDOW: sub_win_q <= cfg_data_i;
          prt_pkg::REG_REFR_COST:  cost_q    <= cfg_data_i[15:0];
          prt_pkg::REG_RET_LIMIT:  ret_lim_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && (op_i != prt_pkg::OP_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        prt_pkg::OP_LATCH: begin
          tick_q   <= in_data_i.func;
          replay_q <= 1'b0;
        end
        prt_pkg::OP_DEFER: begin
          hcnt_q     <= hcnt_q + CW'(1);
          res_st_q   <= prt_pkg::ST_DEFERRED;
          res_part_q <= '0;
          res_idx_q  <= '0;
        end
        prt_pkg::OP_DROP: begin
          res_st_q   <= prt_pkg::ST_DROPPED;
          res_part_q <= 3'(cp_q);
          res_idx_q  <= '0;
        end
        prt_pkg::OP_SWEEP_START: begin
          p_q <= '0;
          i_q <= '0;
        end
        prt_pkg::OP_NEXT_PART: begin
          p_q <= p_q + PW'(1);
          i_q <= '0;
        end
        prt_pkg::OP_TO_CP:      p_q <= cp_q;
        prt_pkg::OP_NEXT_ENTRY: i_q <= i_q + LW'(1);
        prt_pkg::OP_HIT: begin
          if (replay_q) begin
            k_q <= k_q + CW'(1);
          end else begin
            res_st_q   <= prt_pkg::ST_HIT;
            res_part_q <= 3'(p_q);
            res_idx_q  <= 6'(i_q);
          end
        end
        prt_pkg::OP_APPEND: begin
          if (!list_full) begin
            len_q[p_q] <= len_cur + LW'(1);
          end
          if (replay_q) begin
            k_q <= k_q + CW'(1);
          end else begin
            res_st_q   <= list_full ? prt_pkg::ST_DROPPED : prt_pkg::ST_NEW;
            res_part_q <= 3'(p_q);
            res_idx_q  <= list_full ? 6'd0 : 6'(len_cur);
          end
        end
        prt_pkg::OP_TICK_SUMS: begin
          lat_q      <= lat_sum[48] ? prt_pkg::SUM_MAX : lat_sum[47:0];
          bus_q      <= bus_sum_n[48] ? prt_pkg::SUM_MAX : bus_sum_n[47:0];
          res_st_q   <= prt_pkg::ST_TICK;
          res_part_q <= '0;
          res_idx_q  <= '0;
          p_q        <= '0;
          i_q        <= '0;
        end
        prt_pkg::OP_AGE_WR: i_q <= i_q + LW'(1);
        prt_pkg::OP_SET_TAIL: begin
          tail_q[cp_q] <= 32'(len_cur) * 32'(cost_q);
          if (cp_q == PW'(prt_pkg::PARTITIONS - 1)) begin
            cp_q <= '0;
            if (round_q != prt_pkg::U32_MAX) begin
              round_q <= round_q + 32'd1;
            end
          end else begin
            cp_q <= cp_q + PW'(1);
          end
          k_q    <= '0;
          keep_q <= '0;
        end
        prt_pkg::OP_REPLAY_LOAD: replay_q <= 1'b1;
        prt_pkg::OP_KEEP: begin
          keep_q <= keep_q + CW'(1);
          k_q    <= k_q + CW'(1);
        end
        prt_pkg::OP_REPLAY_END: begin
          hcnt_q   <= keep_q;
          replay_q <= 1'b0;
        end
        prt_pkg::OP_RET_START: begin
          ok_q <= 1'b1;
          p_q  <= '0;
          i_q  <= '0;
        end
        prt_pkg::OP_RET_CMP: begin
          if (age_rdata > ret_lim_q) begin
            ok_q <= 1'b0;
          end
          i_q <= i_q + LW'(1);
        end
        prt_pkg::OP_OUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/partitioned_refresh_tracker.sv
// ----------------------------------------------------------------------------
// partitioned_refresh_tracker
// Refresh tracker with one row-group list per refresh partition.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   prt_pkg::in_item_t
//   out       output     out_valid_o / out_ready_i prt_pkg::out_item_t
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One transaction at a time. A deferred or dropped request is dominated by the
// retention sweep, which reads every entry of all lists through the age RAM port. A lookup
// scans the partitions in order and, on a miss, appends to the current partition if its
// list has room; a tick updates the totals, ages all entries and replays held requests.
// No clearing pass follows reset. A waiting result stalls only the final state, S_DONE, and
// does not block acceptance of the next transaction.
module partitioned_refresh_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  prt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output prt_pkg::out_item_t out_data_o
);

  prt_pkg::dp_op_e     op;
  prt_pkg::dp_status_t status;

  prt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .op_o       (op)
  );

  prt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .op_i        (op),
    .status_o    (status)
  );

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the partitioned refresh tracker: a driver feeds
// requests and ticks through valid/ready, a monitor compares each result with
// a behavioral model of the lists, the hold buffer and the totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  prt_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  prt_pkg::out_item_t out_data_o;

  partitioned_refresh_tracker dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  // Model state.
  logic [31:0] m_sub_window;
  logic [15:0] m_cost;
  logic [31:0] m_ret_limit;
  logic [2:0]  m_cur_part;
  logic [31:0] m_rounds;
  logic [9:0]  m_rg  [prt_pkg::PARTITIONS][prt_pkg::LIST_DEPTH];
  logic [31:0] m_age [prt_pkg::PARTITIONS][prt_pkg::LIST_DEPTH];
  int          m_len [prt_pkg::PARTITIONS];
  logic [31:0] m_tail [prt_pkg::PARTITIONS];
  logic [47:0] m_lat_sum;
  logic [47:0] m_bus_sum;
  logic [9:0]  m_held [prt_pkg::HOLD_DEPTH];
  int          m_held_cnt;

  prt_pkg::in_item_t  pending_items[$];
  prt_pkg::out_item_t expected_results[$];
  int        errors = 0;
  bit        calm;      // no idling in the last part of the run
  bit        hold_off;  // sender pauses until everything has drained
  int        in_gap;
  int        out_gap;

  function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? prt_pkg::SUM_MAX : s[47:0];
  endfunction

  function automatic bit offset_fits(logic [31:0] offset);
    logic [31:0] tail;
    tail = m_tail[m_cur_part];
    if (tail >= m_sub_window) return 0;
    return offset < (m_sub_window - tail);
  endfunction

  function automatic logic [2:0] find_or_append(logic [9:0] rg, output logic [2:0] part,
                                                output logic [5:0] idx);
    int n;
    for (int p = 0; p < prt_pkg::PARTITIONS; p++)
      for (int i = 0; i < m_len[p]; i++)
        if (m_rg[p][i] == rg) begin
          m_age[p][i] = 0;
          part = p[2:0];
          idx = i[5:0];
          return prt_pkg::ST_HIT;
        end
    part = m_cur_part;
    n = m_len[m_cur_part];
    if (n >= prt_pkg::LIST_DEPTH) begin
      idx = 0;
      return prt_pkg::ST_DROPPED;
    end
    m_rg[m_cur_part][n] = rg;
    m_age[m_cur_part][n] = 0;
    m_len[m_cur_part] = n + 1;
    idx = n[5:0];
    return prt_pkg::ST_NEW;
  endfunction

  function automatic void close_window();
    logic [31:0] tail;
    logic [31:0] decay;
    logic [32:0] aged;
    logic [2:0]  pp;
    logic [5:0]  ii;
    int          keep;
    int          cp;
    cp = m_cur_part;
    tail = m_tail[cp];
    decay = m_ret_limit / prt_pkg::PARTITIONS;
    m_lat_sum = sat48(m_lat_sum, {16'd0, tail});
    if ({1'b0, tail} + 33'd1 <= {1'b0, m_sub_window})
      m_bus_sum = sat48(m_bus_sum, {16'd0, m_sub_window - tail - 32'd1});
    for (int p = 0; p < prt_pkg::PARTITIONS; p++)
      for (int i = 0; i < m_len[p]; i++) begin
        aged = {1'b0, m_age[p][i]} + {1'b0, decay};
        m_age[p][i] = (p == cp) ? 32'd0 : (aged[32] ? prt_pkg::U32_MAX : aged[31:0]);
      end
    m_tail[cp] = m_len[cp] * m_cost;
    if (cp == prt_pkg::PARTITIONS - 1) begin
      m_cur_part = 0;
      if (m_rounds != prt_pkg::U32_MAX) m_rounds++;
    end else begin
      m_cur_part = 3'(cp + 1);
    end
    keep = 0;
    for (int k = 0; k < m_held_cnt; k++) begin
      if (offset_fits(k)) void'(find_or_append(m_held[k], pp, ii));
      else m_held[keep++] = m_held[k];
    end
    m_held_cnt = keep;
  endfunction

  function automatic prt_pkg::out_item_t predict_tracker(prt_pkg::in_item_t it);
    prt_pkg::out_item_t r;
    logic [2:0] pp;
    logic [5:0] ii;
    r = '0;
    pp = 0;
    ii = 0;
    if (it.func) begin
      close_window();
      r.status = prt_pkg::ST_TICK;
    end else if (offset_fits(it.offset_in_window)) begin
      r.status = find_or_append(it.row_grp, pp, ii);
    end else if (m_held_cnt < prt_pkg::HOLD_DEPTH) begin
      m_held[m_held_cnt++] = it.row_grp;
      r.status = prt_pkg::ST_DEFERRED;
    end else begin
      r.status = prt_pkg::ST_DROPPED;
      pp = m_cur_part;
    end
    r.hit_partition = pp;
    r.hit_index = ii;
    r.retention_ok = 1'b1;
    for (int p = 0; p < prt_pkg::PARTITIONS; p++)
      for (int i = 0; i < m_len[p]; i++)
        if (m_age[p][i] > m_ret_limit) r.retention_ok = 1'b0;
    r.refresh_latency_total = m_lat_sum;
    r.valid_bus_total = m_bus_sum;
    r.window_count = m_rounds;
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Driver: prediction happens at acceptance, so config writes between
  // phases are seen in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_results.push_back(predict_tracker(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!hold_off && pending_items.size() > 0 &&
                     (calm || $urandom_range(0, 5) != 0)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          if (!calm && !hold_off) in_gap <= $urandom_range(0, 2);
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    prt_pkg::out_item_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result status=%0d", out_data_o.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_o.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_data_o.status);
            errors++;
          end
          if (out_data_o.hit_partition !== exp_r.hit_partition) begin
            $error("hit_partition exp %0d got %0d", exp_r.hit_partition,
                   out_data_o.hit_partition);
            errors++;
          end
          if (out_data_o.hit_index !== exp_r.hit_index) begin
            $error("hit_index exp %0d got %0d", exp_r.hit_index, out_data_o.hit_index);
            errors++;
          end
          if (out_data_o.retention_ok !== exp_r.retention_ok) begin
            $error("retention_ok exp %0d got %0d", exp_r.retention_ok,
                   out_data_o.retention_ok);
            errors++;
          end
          if (out_data_o.refresh_latency_total !== exp_r.refresh_latency_total) begin
            $error("refresh_latency_total exp %0d got %0d", exp_r.refresh_latency_total,
                   out_data_o.refresh_latency_total);
            errors++;
          end
          if (out_data_o.valid_bus_total !== exp_r.valid_bus_total) begin
            $error("valid_bus_total exp %0d got %0d", exp_r.valid_bus_total,
                   out_data_o.valid_bus_total);
            errors++;
          end
          if (out_data_o.window_count !== exp_r.window_count) begin
            $error("window_count exp %0d got %0d", exp_r.window_count,
                   out_data_o.window_count);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (calm || $urandom_range(0, 4) != 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        out_gap <= $urandom_range(0, 2);
      end
    end
  end

  task automatic add_item(bit func, logic [31:0] offset, logic [9:0] rg);
    prt_pkg::in_item_t it;
    it.func = func;
    it.offset_in_window = offset;
    it.row_grp = rg;
    pending_items.push_back(it);
  endtask

  // Waits until every queued item has been accepted and answered, then lets
  // the block finish any background work before a register write.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      prt_pkg::REG_SUB_WINDOW: m_sub_window = val;
      prt_pkg::REG_REFR_COST:  m_cost = val[15:0];
      prt_pkg::REG_RET_LIMIT:  m_ret_limit = val;
      default: ;
    endcase
  endtask

  // Random requests mostly reuse a small pool of row groups, so hits, full
  // lists and deferrals all happen; ticks keep windows and replays moving.
  task automatic random_phase(int count, int pool);
    logic [31:0] off;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1: off = $urandom();
        2:    off = m_sub_window - $urandom_range(0, 3);
        default: off = $urandom_range(0, 2000);
      endcase
      if ($urandom_range(0, 6) == 0) add_item(1'b1, $urandom(), 10'($urandom()));
      else add_item(1'b0, off, 10'($urandom_range(0, 4) == 0 ? $urandom() :
                                   $urandom_range(0, pool - 1)));
    end
  endtask

  initial begin
    calm = 0;
    hold_off = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = prt_pkg::REG_SUB_WINDOW;
    cfg_data_i = '0;
    m_sub_window = 32'd8000000;
    m_cost = 16'd350;
    m_ret_limit = 32'd64000000;
    m_cur_part = 0;
    m_rounds = 0;
    m_lat_sum = 0;
    m_bus_sum = 0;
    m_held_cnt = 0;
    for (int p = 0; p < prt_pkg::PARTITIONS; p++) begin
      m_len[p] = 0;
      m_tail[p] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, hit, offset past the window, hold overflow,
    // tick with replay.
    add_item(1'b0, 32'd0, 10'd0);
    add_item(1'b0, 32'd7999999, 10'h3FF);
    add_item(1'b0, 32'd5, 10'd0);
    add_item(1'b0, 32'hFFFFFFFF, 10'h155);
    for (int k = 0; k < prt_pkg::HOLD_DEPTH; k++)
      add_item(1'b0, 32'd8000000, 10'(10'h2AA + k));
    add_item(1'b1, 32'hFFFFFFFF, 10'h3FF);
    add_item(1'b0, 32'd100, 10'h155);
    add_item(1'b1, 32'd0, 10'd0);
    drain();

    // Small window and large cost: tails overrun the window.
    write_reg(prt_pkg::REG_SUB_WINDOW, 32'd1);
    write_reg(prt_pkg::REG_REFR_COST, 32'h0000FFFF);
    write_reg(prt_pkg::REG_RET_LIMIT, 32'd1);
    add_item(1'b0, 32'd0, 10'd7);
    add_item(1'b1, 32'd0, 10'd0);
    for (int k = 0; k < 8; k++) add_item(1'b1, 32'd0, 10'd0);
    drain();

    write_reg(prt_pkg::REG_SUB_WINDOW, 32'd5000);
    write_reg(prt_pkg::REG_REFR_COST, 32'd0);
    write_reg(prt_pkg::REG_RET_LIMIT, 32'd2000);
    for (int k = 0; k < prt_pkg::LIST_DEPTH + 2; k++) add_item(1'b0, 32'd1, k[9:0] + 10'd100);
    random_phase(120, 200);
    // Sender holds back until everything has come back.
    while (pending_items.size() > 100) @(posedge clk_i);
    hold_off = 1;
    while (expected_results.size() > 0 || in_valid_i) @(posedge clk_i);
    hold_off = 0;
    drain();

    write_reg(prt_pkg::REG_SUB_WINDOW, 32'hFFFFFFFF);
    write_reg(prt_pkg::REG_REFR_COST, 32'd40);
    write_reg(prt_pkg::REG_RET_LIMIT, 32'hFFFFFFFF);
    random_phase(100, 500);
    drain();

    write_reg(prt_pkg::REG_SUB_WINDOW, 32'd3000);
    write_reg(prt_pkg::REG_REFR_COST, 32'd25);
    write_reg(prt_pkg::REG_RET_LIMIT, 32'd9000);
    random_phase(150, 300);
    while (pending_items.size() > 40) @(posedge clk_i);
    calm = 1;
    random_phase(150, 1024);
    drain();

    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #600ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

FILE: partitioned_refresh_tracker.f
hw/rtl/prt_pkg.sv
hw/rtl/prt_ram.sv
hw/rtl/prt_ctrl.sv
hw/rtl/prt_dp.sv
hw/rtl/partitioned_refresh_tracker.sv
bench/tb_top.sv
